// ===== src/assert_macros.svh =====
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define OLE_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked check that also holds during reset
`define OLE_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== src/ole_pkg.sv =====
package ole_pkg;

    // field widths of one input item and one result item
    localparam int ACTION_W   = 3;
    localparam int POS_W      = 7;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 7;
    localparam int MIDX_W     = 6;
    localparam int RVAL_W     = 32;

    // stream word layouts, lowest field first, padded to whole bytes
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;
    localparam int IN_USED_W   = ACTION_W + POS_W + VALUE_W;
    localparam int OUT_USED_W  = STATUS_W + COUNT_W + 1 + MIDX_W + RVAL_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_POP_BACK   = 3'd1,
        ACT_PUSH_FRONT = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_INSERT     = 3'd4,
        ACT_ERASE      = 3'd5,
        ACT_FIND       = 3'd6,
        ACT_READ       = 3'd7
    } act_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_EMPTY     = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_BAD_POS   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_UP_RD,
        S_UP_WR,
        S_INS_WR,
        S_DN_RD,
        S_DN_WR,
        S_FIND_RD,
        S_FIND_CMP,
        S_READ_RD,
        S_READ_CAP,
        S_RESPOND
    } state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_COUNT,
        IDX_POS,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_IDX_M1,
        RD_IDX_P1
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_VAL_AT_COUNT,
        WR_VAL_AT_IDX,
        WR_DATA_AT_IDX
    } wr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic    load_op;
        idx_op_t idx_op;
        rd_sel_t rd_sel;
        wr_op_t  wr_op;
        cnt_op_t cnt_op;
        logic    res_set;
        status_t res_code;
        logic    find_hit;
        logic    read_cap;
        logic    out_load;
    } cmd_t;

    // conditions from the datapath back to the sequencer
    typedef struct packed {
        act_t action;
        logic empty;
        logic full;
        logic pos_gt_count;
        logic pos_ge_count;
        logic up_more;
        logic dn_first;
        logic dn_more;
        logic find_last;
        logic match;
        logic out_free;
    } stat_t;

endpackage

// ===== src/ordered_list_engine_unit.sv =====
// Ordered list engine: a fixed list of up to CAPACITY signed words held in one
// single-port-write, single-port-read memory, serving one operation per input
// transfer (push/pop at either end, insert, erase, find, read) and returning
// one result transfer with status, element count, found flag, match index and
// read value. Items are handled one at a time by a sequencer that owns the
// memory port: push back, pop back and every rejected operation go from decode
// to the result; insert and push front move entries up by a read and write,
// erase and pop front move entries down, find compares entries in turn and
// read reads then captures. The finished result sits in an output register,
// so the next item is taken while it waits. No clearing pass runs after reset.
module ordered_list_engine_unit
    import ole_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // action[2:0], position[9:3], value[41:10], zero pad above
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // status[2:0], element_count[9:3], found[10], match_index[16:11],
    // read_value[48:17], zero pad above
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer
    ole_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // store, index walk and result registers
    ole_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// ===== src/ole_ctrl.sv =====
module ole_ctrl
    import ole_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.action)
                    ACT_PUSH_BACK, ACT_POP_BACK:
                    begin
                        state_next = S_RESPOND;
                    end
                    ACT_PUSH_FRONT, ACT_INSERT:
                    begin
                        if (stat.pos_gt_count || stat.full)
                        begin
                            state_next = S_RESPOND;
                        end
                        else if (!stat.pos_ge_count)
                        begin
                            state_next = S_UP_RD;
                        end
                        else
                        begin
                            state_next = S_INS_WR;
                        end
                    end
                    ACT_POP_FRONT, ACT_ERASE:
                    begin
                        if (!stat.empty && !stat.pos_ge_count && stat.dn_first)
                        begin
                            state_next = S_DN_RD;
                        end
                        else
                        begin
                            state_next = S_RESPOND;
                        end
                    end
                    ACT_FIND:
                    begin
                        state_next = stat.empty ? S_RESPOND : S_FIND_RD;
                    end
                    ACT_READ:
                    begin
                        state_next = stat.pos_ge_count ? S_RESPOND : S_READ_RD;
                    end
                endcase
            end
            S_UP_RD:
            begin
                state_next = S_UP_WR;
            end
            S_UP_WR:
            begin
                state_next = stat.up_more ? S_UP_RD : S_INS_WR;
            end
            S_INS_WR:
            begin
                state_next = S_RESPOND;
            end
            S_DN_RD:
            begin
                state_next = S_DN_WR;
            end
            S_DN_WR:
            begin
                state_next = stat.dn_more ? S_DN_RD : S_RESPOND;
            end
            S_FIND_RD:
            begin
                state_next = S_FIND_CMP;
            end
            S_FIND_CMP:
            begin
                if (stat.match || stat.find_last)
                begin
                    state_next = S_RESPOND;
                end
                else
                begin
                    state_next = S_FIND_RD;
                end
            end
            S_READ_RD:
            begin
                state_next = S_READ_CAP;
            end
            S_READ_CAP:
            begin
                state_next = S_RESPOND;
            end
            S_RESPOND:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.idx_op   = IDX_HOLD;
        cmd.rd_sel   = RD_IDX;
        cmd.wr_op    = WR_NONE;
        cmd.cnt_op   = CNT_HOLD;
        cmd.res_code = STAT_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_op = s_tvalid;
            end
            S_DECODE:
            begin
                unique case (stat.action)
                    ACT_PUSH_BACK:
                    begin
                        if (stat.full)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = STAT_FULL;
                        end
                        else
                        begin
                            cmd.wr_op  = WR_VAL_AT_COUNT;
                            cmd.cnt_op = CNT_INC;
                        end
                    end
                    ACT_POP_BACK:
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = STAT_EMPTY;
                        end
                        else
                        begin
                            cmd.cnt_op = CNT_DEC;
                        end
                    end
                    ACT_PUSH_FRONT, ACT_INSERT:
                    begin
                        // position is checked before fullness
                        if (stat.pos_gt_count)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = STAT_BAD_POS;
                        end
                        else if (stat.full)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = STAT_FULL;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_COUNT;
                        end
                    end
                    ACT_POP_FRONT, ACT_ERASE:
                    begin
                        // emptiness is checked before position
                        if (stat.empty)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = STAT_EMPTY;
                        end
                        else if (stat.pos_ge_count)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = STAT_BAD_POS;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_POS;
                            if (!stat.dn_first)
                            begin
                                cmd.cnt_op = CNT_DEC;
                            end
                        end
                    end
                    ACT_FIND:
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = STAT_NOT_FOUND;
                        cmd.idx_op   = IDX_ZERO;
                    end
                    ACT_READ:
                    begin
                        if (stat.pos_ge_count)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = STAT_BAD_POS;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_POS;
                        end
                    end
                endcase
            end
            S_UP_RD:
            begin
                cmd.rd_sel = RD_IDX_M1;
            end
            S_UP_WR:
            begin
                cmd.wr_op  = WR_DATA_AT_IDX;
                cmd.idx_op = IDX_DEC;
            end
            S_INS_WR:
            begin
                cmd.wr_op  = WR_VAL_AT_IDX;
                cmd.cnt_op = CNT_INC;
            end
            S_DN_RD:
            begin
                cmd.rd_sel = RD_IDX_P1;
            end
            S_DN_WR:
            begin
                cmd.wr_op  = WR_DATA_AT_IDX;
                cmd.idx_op = IDX_INC;
                if (!stat.dn_more)
                begin
                    cmd.cnt_op = CNT_DEC;
                end
            end
            S_FIND_RD:
            begin
                cmd.rd_sel = RD_IDX;
            end
            S_FIND_CMP:
            begin
                if (stat.match)
                begin
                    cmd.find_hit = 1'b1;
                end
                else if (!stat.find_last)
                begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_READ_RD:
            begin
                cmd.rd_sel = RD_IDX;
            end
            S_READ_CAP:
            begin
                cmd.read_cap = 1'b1;
            end
            S_RESPOND:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/ole_datapath.sv =====
module ole_datapath
    import ole_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  cmd_t                   cmd,
    output stat_t                  stat
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 2;
    localparam int XW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

    // input fields
    act_t               in_action;
    logic [POS_W-1:0]   in_pos;
    logic [VALUE_W-1:0] in_value;
    logic [XW-1:0]      in_value_x;

    // latched operation
    act_t                  act_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [DATA_WIDTH-1:0] val_reg;

    // list state and walk index
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic [CW-1:0] idx_m1;
    logic [CW-1:0] idx_p1;

    // element store
    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [IW-1:0]         rd_addr;
    logic [IW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  wr_en;

    // pending result
    status_t           res_status_reg;
    logic              res_found_reg;
    logic [MIDX_W-1:0] res_midx_reg;
    logic [RVAL_W-1:0] res_rval_reg;

    // output register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_TDATA_W-1:0] out_tdata_reg;

    // widened operands for compares
    logic [PW-1:0] pos_x;
    logic [PW-1:0] cnt_x;
    logic [PW-1:0] idx_x;

    assign in_action  = act_t'(s_tdata[ACTION_W-1:0]);
    assign in_pos     = s_tdata[ACTION_W +: POS_W];
    assign in_value   = s_tdata[ACTION_W + POS_W +: VALUE_W];
    assign in_value_x = XW'(in_value);

    // operation latch, front actions work at position zero
    always_ff @(posedge clk)
    begin
        if (cmd.load_op)
        begin
            act_reg <= in_action;
            val_reg <= in_value_x[DATA_WIDTH-1:0];
            if ((in_action == ACT_PUSH_FRONT) || (in_action == ACT_POP_FRONT))
            begin
                pos_reg <= '0;
            end
            else
            begin
                pos_reg <= in_pos;
            end
        end
    end

    // status flags for the sequencer
    assign pos_x = PW'(pos_reg);
    assign cnt_x = PW'(count_reg);
    assign idx_x = PW'(idx_reg);

    always_comb
    begin
        stat.action       = act_reg;
        stat.empty        = (count_reg == '0);
        stat.full         = (count_reg == CW'(CAPACITY));
        stat.pos_gt_count = (pos_x > cnt_x);
        stat.pos_ge_count = (pos_x >= cnt_x);
        stat.up_more      = (idx_x > (pos_x + PW'(1)));
        stat.dn_first     = ((pos_x + PW'(1)) < cnt_x);
        stat.dn_more      = ((idx_x + PW'(2)) < cnt_x);
        stat.find_last    = ((idx_x + PW'(1)) >= cnt_x);
        stat.match        = (rd_data_reg == val_reg);
        stat.out_free     = !out_valid_reg || m_tready;
    end

    // count register
    always_comb
    begin
        unique case (cmd.cnt_op)
            CNT_INC: count_next = count_reg + CW'(1);
            CNT_DEC: count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // walk index
    assign idx_m1 = idx_reg - CW'(1);
    assign idx_p1 = idx_reg + CW'(1);

    always_comb
    begin
        unique case (cmd.idx_op)
            IDX_COUNT: idx_next = count_reg;
            IDX_POS:   idx_next = CW'(pos_reg);
            IDX_ZERO:  idx_next = '0;
            IDX_INC:   idx_next = idx_p1;
            IDX_DEC:   idx_next = idx_m1;
            default:   idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
    end

    // memory port addressing
    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_IDX_M1: rd_addr = idx_m1[IW-1:0];
            RD_IDX_P1: rd_addr = idx_p1[IW-1:0];
            default:   rd_addr = idx_reg[IW-1:0];
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = idx_reg[IW-1:0];
        wr_data = val_reg;
        unique case (cmd.wr_op)
            WR_VAL_AT_COUNT: wr_addr = count_reg[IW-1:0];
            WR_VAL_AT_IDX:   wr_data = val_reg;
            WR_DATA_AT_IDX:  wr_data = rd_data_reg;
            default:         wr_en   = 1'b0;
        endcase
    end

    // element store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // pending result
    always_ff @(posedge clk)
    begin
        if (cmd.load_op)
        begin
            res_status_reg <= STAT_OK;
            res_found_reg  <= 1'b0;
            res_midx_reg   <= '0;
            res_rval_reg   <= '0;
        end
        else
        begin
            if (cmd.res_set)
            begin
                res_status_reg <= cmd.res_code;
            end
            if (cmd.find_hit)
            begin
                res_status_reg <= STAT_OK;
                res_found_reg  <= 1'b1;
                res_midx_reg   <= MIDX_W'(idx_reg);
            end
            if (cmd.read_cap)
            begin
                res_rval_reg <= RVAL_W'(signed'(rd_data_reg));
            end
        end
    end

    // output register, freed by a transfer on the result side
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_tdata_reg <= {
                (OUT_TDATA_W - OUT_USED_W)'(0),
                res_rval_reg,
                res_midx_reg,
                res_found_reg,
                COUNT_W'(count_reg),
                res_status_reg
            };
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;

endmodule

// ===== src/ole_checker.sv =====
`include "assert_macros.svh"

module ole_checker
    import ole_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_TDATA_W-1:0]  s_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic              res_found;
    logic [MIDX_W-1:0] res_midx;
    logic [STATUS_W-1:0] res_status;
    logic [COUNT_W-1:0]  res_count;

    assign res_status = m_tdata[STATUS_W-1:0];
    assign res_count  = m_tdata[STATUS_W +: COUNT_W];
    assign res_found  = m_tdata[STATUS_W + COUNT_W];
    assign res_midx   = m_tdata[STATUS_W + COUNT_W + 1 +: MIDX_W];

    // no result is offered while reset is held
    `OLE_ASSERT_RST(a_no_result_in_reset, !rst_n |-> !m_tvalid, "result offered in reset")

    // a stalled result stays put
    `OLE_ASSERT_CLK(a_result_held, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // a hit always reports success
    `OLE_ASSERT_CLK(a_found_ok, m_tvalid && res_found |-> res_status == STAT_OK, "found without ok status")

    // no hit, no index
    `OLE_ASSERT_CLK(a_midx_zero, m_tvalid && !res_found |-> res_midx == '0, "match index without a hit")

    // the list never grows past its capacity
    `OLE_ASSERT_CLK(a_count_cap, m_tvalid |-> (CAPACITY > 127) || (res_count <= COUNT_W'(CAPACITY)), "count above capacity")

endmodule

bind ordered_list_engine_unit ole_checker #(.CAPACITY(CAPACITY)) u_ole_checker (.*);

// ===== tb/ordered_list_engine_unit_tb.sv =====
`timescale 1ns / 100ps

module ordered_list_engine_unit_tb;

    import ole_pkg::*;

    localparam int LIST_CAP = 64;

    // one result transfer as the block should produce it
    typedef struct {
        status_t     status;
        logic [6:0]  count;
        logic        found;
        logic [5:0]  midx;
        logic [31:0] rval;
    } list_reply_t;

    // shadow copy of the list plus the replies still owed by the block
    class list_shadow;
        logic [31:0] elems [0:LIST_CAP-1];
        int          level;
        int          ops_taken;
        int          replies_seen;
        int          errors;
        list_reply_t pending[$];

        function new();
            level        = 0;
            ops_taken    = 0;
            replies_seen = 0;
            errors       = 0;
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("mismatch at %0t: %s", $realtime, what);
        endtask

        // apply one accepted operation and queue the reply it must produce
        function void note_op(act_t act, logic [6:0] pos, logic [31:0] val);
            list_reply_t r;
            int          p;
            int          i;
            r.status = STAT_OK;
            r.found  = 1'b0;
            r.midx   = '0;
            r.rval   = '0;
            p        = int'(pos);
            case (act)
                ACT_PUSH_BACK:
                begin
                    if (level >= LIST_CAP)
                    begin
                        r.status = STAT_FULL;
                    end
                    else
                    begin
                        elems[level] = val;
                        level++;
                    end
                end
                ACT_POP_BACK:
                begin
                    if (level == 0)
                        r.status = STAT_EMPTY;
                    else
                        level--;
                end
                ACT_PUSH_FRONT, ACT_INSERT:
                begin
                    if (act == ACT_PUSH_FRONT)
                        p = 0;
                    if (p > level)
                    begin
                        r.status = STAT_BAD_POS;
                    end
                    else if (level >= LIST_CAP)
                    begin
                        r.status = STAT_FULL;
                    end
                    else
                    begin
                        for (i = level; i > p; i--)
                            elems[i] = elems[i-1];
                        elems[p] = val;
                        level++;
                    end
                end
                ACT_POP_FRONT, ACT_ERASE:
                begin
                    if (act == ACT_POP_FRONT)
                        p = 0;
                    if (level == 0)
                    begin
                        r.status = STAT_EMPTY;
                    end
                    else if (p >= level)
                    begin
                        r.status = STAT_BAD_POS;
                    end
                    else
                    begin
                        for (i = p; i + 1 < level; i++)
                            elems[i] = elems[i+1];
                        level--;
                    end
                end
                ACT_FIND:
                begin
                    r.status = STAT_NOT_FOUND;
                    for (i = 0; i < level && !r.found; i++)
                    begin
                        if (elems[i] == val)
                        begin
                            r.status = STAT_OK;
                            r.found  = 1'b1;
                            r.midx   = i[5:0];
                        end
                    end
                end
                default:
                begin
                    if (p >= level)
                        r.status = STAT_BAD_POS;
                    else
                        r.rval = elems[p];
                end
            endcase
            r.count = level[6:0];
            pending.push_back(r);
            ops_taken++;
        endfunction

        // compare one result transfer with the oldest owed reply
        task check_reply(logic [OUT_TDATA_W-1:0] word);
            list_reply_t want;
            int          n;
            n = replies_seen;
            replies_seen++;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("reply %0d arrived with nothing outstanding", n));
                return;
            end
            want = pending.pop_front();
            if (word[2:0] !== want.status)
                report_mismatch($sformatf("reply %0d status %0d, want %0d",
                                          n, word[2:0], want.status));
            if (word[9:3] !== want.count)
                report_mismatch($sformatf("reply %0d count %0d, want %0d",
                                          n, word[9:3], want.count));
            if (word[10] !== want.found)
                report_mismatch($sformatf("reply %0d found %0b, want %0b",
                                          n, word[10], want.found));
            if (word[16:11] !== want.midx)
                report_mismatch($sformatf("reply %0d match index %0d, want %0d",
                                          n, word[16:11], want.midx));
            if (word[48:17] !== want.rval)
                report_mismatch($sformatf("reply %0d read value %h, want %h",
                                          n, word[48:17], want.rval));
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    list_shadow shadow;
    int         burst_left;

    ordered_list_engine_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    // sender pacing: bursts of back-to-back offers split by idle gaps
    task pace();
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
        end
        burst_left--;
    endtask

    // offer one operation and hold it until the input transfer happens
    task send_op(act_t act, int pos, logic [31:0] val);
        logic [6:0] p7;
        pace();
        p7 = pos[6:0];
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, val, p7, act};
        do
            @(posedge clk);
        while (!s_tready);
        shadow.note_op(act, p7, val);
        @(negedge clk);
    endtask

    // sender stops until every owed reply has come back
    task wait_replies();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (shadow.pending.size() != 0);
        burst_left = 0;
    endtask

    // half the time a few clustered or extreme values so finds hit and duplicates exist
    function logic [31:0] pick_value();
        int v;
        case ($urandom_range(0, 7))
            0, 1, 2:
            begin
                v = $urandom_range(0, 7);
                return v - 3;
            end
            3:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // in-range index most of the time, any position now and then
    function int pick_index(int limit);
        if (limit <= 0 || $urandom_range(0, 9) == 0)
            return $urandom_range(0, LIST_CAP);
        return $urandom_range(0, limit - 1);
    endfunction

    // one random operation drawn from add, remove and lookup weights
    task random_op(int w_add, int w_rem, int w_look);
        int          roll;
        int          lvl;
        int          pos;
        logic [31:0] val;
        act_t        act;
        roll = $urandom_range(0, w_add + w_rem + w_look - 1);
        lvl  = shadow.level;
        pos  = $urandom_range(0, LIST_CAP);
        val  = pick_value();
        if (roll < w_add)
        begin
            case ($urandom_range(0, 2))
                0: act = ACT_PUSH_BACK;
                1: act = ACT_PUSH_FRONT;
                default:
                begin
                    act = ACT_INSERT;
                    pos = pick_index(lvl + 1);
                end
            endcase
        end
        else if (roll < w_add + w_rem)
        begin
            case ($urandom_range(0, 2))
                0: act = ACT_POP_BACK;
                1: act = ACT_POP_FRONT;
                default:
                begin
                    act = ACT_ERASE;
                    pos = pick_index(lvl);
                end
            endcase
        end
        else if ($urandom_range(0, 1) == 0)
        begin
            act = ACT_FIND;
            if (lvl > 0 && $urandom_range(0, 2) != 0)
                val = shadow.elems[$urandom_range(0, lvl - 1)];
        end
        else
        begin
            act = ACT_READ;
            pos = pick_index(lvl);
        end
        send_op(act, pos, val);
    endtask

    // result side: check every result transfer
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                shadow.check_reply(m_tdata);
        end
    end

    // receiver stall pattern, with one long hold-off once 200 operations have been taken
    initial
    begin
        int  mode;
        int  mode_left;
        int  period;
        int  phase;
        int  hold_left;
        bit  hold_done;
        mode      = 0;
        mode_left = 0;
        period    = 2;
        phase     = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && shadow.ops_taken >= 200)
            begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 4);
                mode_left = $urandom_range(20, 200);
                period    = $urandom_range(2, 9);
            end
            mode_left--;
            phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) != 0);
                    2: m_tready <= ($urandom_range(0, 7) != 0);
                    3: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ((phase % period) < (period / 2));
                endcase
            end
        end
    end

    // run limit
    initial
    begin
        #4_000_000;
        $display("ordered_list_engine_unit_tb failed");
        $finish;
    end

    // reset, directed operations, then phased random traffic
    initial
    begin
        int ph;
        int k;
        clk        = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        burst_left = 0;
        shadow     = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty list corners
        send_op(ACT_POP_BACK,   0, 32'd0);
        send_op(ACT_POP_FRONT,  0, 32'd0);
        send_op(ACT_ERASE,      5, 32'd0);
        send_op(ACT_READ,       0, 32'd0);
        send_op(ACT_FIND,       0, 32'd0);
        send_op(ACT_INSERT,     1, 32'd9);
        // build a short list of extreme values
        send_op(ACT_PUSH_BACK,  64, 32'h7fff_ffff);
        send_op(ACT_PUSH_FRONT, 0,  32'h8000_0000);
        send_op(ACT_INSERT,     1,  32'h0000_0000);
        send_op(ACT_INSERT,     3,  32'hffff_ffff);
        send_op(ACT_READ,       0,  32'd0);
        send_op(ACT_READ,       3,  32'd0);
        send_op(ACT_READ,       4,  32'd0);
        send_op(ACT_FIND,       0,  32'hffff_ffff);
        send_op(ACT_FIND,       64, 32'h7fff_ffff);
        send_op(ACT_FIND,       0,  32'h0001_2345);
        // bad positions, then take it apart again
        send_op(ACT_INSERT,     64, 32'h5a5a_a5a5);
        send_op(ACT_ERASE,      4,  32'd0);
        send_op(ACT_ERASE,      64, 32'd0);
        send_op(ACT_ERASE,      1,  32'd0);
        send_op(ACT_POP_FRONT,  0,  32'd0);
        send_op(ACT_POP_BACK,   0,  32'd0);
        send_op(ACT_READ,       64, 32'd0);
        send_op(ACT_POP_BACK,   0,  32'd0);
        wait_replies();

        // fill, churn at full, drain, balanced; twice over
        for (ph = 0; ph < 8; ph++)
        begin
            if (ph == 4)
                wait_replies();
            for (k = 0; k < 150; k++)
            begin
                case (ph % 4)
                    0: random_op(70, 15, 15);
                    1: random_op(45, 35, 20);
                    2: random_op(15, 70, 15);
                    default: random_op(35, 35, 30);
                endcase
            end
        end

        s_tvalid <= 1'b0;
        while (shadow.pending.size() != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
        if (shadow.pending.size() != 0)
            shadow.report_mismatch($sformatf("%0d replies never arrived",
                                             shadow.pending.size()));
        if (shadow.errors == 0)
            $display("ordered_list_engine_unit_tb passed");
        else
            $display("ordered_list_engine_unit_tb failed");
        $finish;
    end

endmodule
